FILE: rtl/core/knnhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnhc_pkg
// Shared sizes, codes and types of the histogram nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package knnhc_pkg;

  localparam int BINS       = 256;
  localparam int NEIGHBOURS = 3;
  localparam int COUNT_BITS = 16;

  localparam int IDX_W   = 8;
  localparam int VALUE_W = 16;
  localparam int DIST_W  = 40;

  // the bin index port is 8 bits, so at most 256 query bins can be addressed
  localparam int QDEPTH = (BINS < (1 << IDX_W)) ? BINS : (1 << IDX_W);
  localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam int PROD_W = 2 * COUNT_BITS;
  localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;

  localparam int FILL_W = $clog2(NEIGHBOURS + 1);
  localparam int NIDX_W = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_TRAIN  = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_INS,
    S_VOTE,
    S_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_FAR,
    N_REPL,
    N_NEAR,
    N_VOTE
  } nbr_state_t;

  typedef struct packed {
    logic mul;
    logic acc;
    logic add_en;
    logic clr;
  } dist_ctrl_t;

  typedef struct packed {
    logic ins;
    logic vote;
    logic label;
    logic qcls;
  } nbr_cmd_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic predicted;
    logic decided;
    logic keep;
  } nbr_stat_t;

  function automatic logic bin_in_range(input logic [IDX_W-1:0] idx);
    return int'(idx) < BINS;
  endfunction

endpackage

FILE: rtl/core/knn_histogram_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_histogram_classifier_unit
// Nearest-neighbor vote between two classes over streamed histograms.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high while
// it is worked on. A query bin is stored as it is taken. A training bin goes
// through the query store read, one squarer and one saturating accumulate.
// The last bin of a sample that goes into the list adds an insert step, and
// when the list is full the shared comparator then walks the entries one a
// cycle to find the farthest. A finish runs the nearest search and vote, or
// none with an empty list, and gives its result on predicted_class, decided
// and keep_query for exactly one cycle with done high; the receiver cannot
// stall it. Other items give no result.
// ----------------------------------------------------------------------------
module knn_histogram_classifier_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [knnhc_pkg::IDX_W-1:0]       bin_index,
  input  logic [knnhc_pkg::VALUE_W-1:0]     bin_value,
  input  logic                              last_bin,
  input  logic                              sample_class,
  input  logic                              exclude_sample,
  input  logic                              query_class,
  output logic                              done,
  output logic                              predicted_class,
  output logic                              decided,
  output logic                              keep_query
);
  import knnhc_pkg::*;

  top_state_t state, state_next;

  logic                  accept;
  op_t                   op_code;
  logic                  in_range;
  logic [COUNT_BITS-1:0] val_in;
  logic                  q_we, q_re;
  logic [COUNT_BITS-1:0] q_rdata;

  logic [COUNT_BITS-1:0] val_r;
  logic                  in_range_r;
  logic                  last_r;
  logic                  cls_r;
  logic                  excl_r;
  logic                  qcls_r;

  dist_ctrl_t            dctrl;
  logic [DIST_W-1:0]     sum;
  nbr_cmd_t              ncmd;
  nbr_stat_t             nstat;

  assign accept   = start && !busy;
  assign op_code  = op_t'(op);
  assign in_range = bin_in_range(bin_index);
  assign val_in   = bin_value[COUNT_BITS-1:0];
  assign busy     = (state != S_IDLE);

  assign q_we = accept && (op_code == OP_QUERY) && in_range;
  assign q_re = accept && (op_code == OP_TRAIN);

  knnhc_qmem u_qmem (
    .clk   (clk),
    .we    (q_we),
    .re    (q_re),
    .addr  (bin_index[QA_W-1:0]),
    .wdata (val_in),
    .rdata (q_rdata)
  );

  knnhc_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (dctrl),
    .q_bin (q_rdata),
    .t_bin (val_r),
    .sum   (sum)
  );

  knnhc_nbr u_nbr (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ncmd),
    .d    (sum),
    .stat (nstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r      <= val_in;
      in_range_r <= in_range;
      last_r     <= last_bin;
      cls_r      <= sample_class;
      excl_r     <= exclude_sample;
      qcls_r     <= query_class;
    end
  end

  always_comb begin
    state_next   = state;
    dctrl        = '0;
    dctrl.add_en = in_range_r;
    ncmd         = '0;
    ncmd.label   = cls_r;
    ncmd.qcls    = qcls_r;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_code)
            OP_TRAIN:  state_next = S_MUL;
            OP_FINISH: state_next = S_VOTE;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        dctrl.mul  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        dctrl.acc = 1'b1;
        if (last_r && excl_r) begin
          // the query itself: drop the sample
          dctrl.clr  = 1'b1;
          state_next = S_IDLE;
        end else if (last_r) begin
          state_next = S_INS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INS: begin
        ncmd.ins   = 1'b1;
        dctrl.clr  = 1'b1;
        state_next = S_WAIT;
      end
      S_VOTE: begin
        ncmd.vote  = 1'b1;
        dctrl.clr  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!nstat.busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign done            = nstat.res_valid;
  assign predicted_class = nstat.predicted;
  assign decided         = nstat.decided;
  assign keep_query      = nstat.keep;

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_WAIT))
    else $error("result strobe outside list wait");

  a_no_result_for_bins: assert property (@(posedge clk) disable iff (rst)
    (accept && op_code != OP_FINISH) |=> !done)
    else $error("result after a non-finish item");

  a_undecided_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !decided) |-> (!predicted_class && !keep_query))
    else $error("undecided result carries a class");

  a_busy_after_finish: assert property (@(posedge clk) disable iff (rst)
    (accept && op_code == OP_FINISH) |=> busy)
    else $error("finish item not held busy");

endmodule

FILE: rtl/core/knnhc_qmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnhc_qmem
// Query histogram store, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module knnhc_qmem (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [knnhc_pkg::QA_W-1:0]        addr,
  input  logic [knnhc_pkg::COUNT_BITS-1:0]  wdata,
  output logic [knnhc_pkg::COUNT_BITS-1:0]  rdata
);
  import knnhc_pkg::*;

  logic [COUNT_BITS-1:0] mem [QDEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/knnhc_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnhc_dist
// Squared bin difference and saturating distance accumulator.
// ----------------------------------------------------------------------------
module knnhc_dist (
  input  logic                              clk,
  input  logic                              rst,
  input  knnhc_pkg::dist_ctrl_t             ctrl,
  input  logic [knnhc_pkg::COUNT_BITS-1:0]  q_bin,
  input  logic [knnhc_pkg::COUNT_BITS-1:0]  t_bin,
  output logic [knnhc_pkg::DIST_W-1:0]      sum
);
  import knnhc_pkg::*;

  logic [COUNT_BITS-1:0] diff;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      acc_wide;
  logic [DIST_W-1:0]     acc_sat;

  assign diff     = (q_bin >= t_bin) ? q_bin - t_bin : t_bin - q_bin;
  assign acc_wide = SUM_W'(sum) + SUM_W'(prod);
  assign acc_sat  = (acc_wide > SUM_W'(DIST_MAX)) ? DIST_MAX : acc_wide[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= PROD_W'(diff) * PROD_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.clr) begin
      sum <= '0;
    end else if (ctrl.acc && ctrl.add_en) begin
      sum <= acc_sat;
    end
  end

endmodule

FILE: rtl/core/knnhc_nbr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnhc_nbr
// Neighbor list, one shared distance comparator: append on insert, or when
// full replace the farthest entry; nearest search and majority vote on finish.
// ----------------------------------------------------------------------------
module knnhc_nbr (
  input  logic                          clk,
  input  logic                          rst,
  input  knnhc_pkg::nbr_cmd_t           cmd,
  input  logic [knnhc_pkg::DIST_W-1:0]  d,
  output knnhc_pkg::nbr_stat_t          stat
);
  import knnhc_pkg::*;

  nbr_state_t state, state_next;

  logic [DIST_W-1:0] nbr_dist [NEIGHBOURS];
  logic              lab  [NEIGHBOURS];
  logic [FILL_W-1:0] fill;
  logic [NIDX_W-1:0] ptr;
  logic [DIST_W-1:0] best_dist;
  logic [NIDX_W-1:0] best_idx;
  logic              best_label;
  logic [FILL_W-1:0] votes1;
  logic [DIST_W-1:0] d_r;
  logic              lab_r;
  logic              qcls_r;
  logic              res_valid;
  logic              pred, dec, keep;

  logic              full;
  logic [NIDX_W-1:0] fill_idx;
  logic              ptr_last;
  logic              ptr_end;
  logic [DIST_W-1:0] cmp_a, cmp_b;
  logic              lt;
  logic [FILL_W-1:0] votes0;
  logic              pred_c;

  assign full     = (fill == FILL_W'(NEIGHBOURS));
  assign fill_idx = fill[NIDX_W-1:0];
  assign ptr_last = (ptr == NIDX_W'(NEIGHBOURS - 1));
  assign ptr_end  = ((FILL_W'(ptr) + FILL_W'(1)) == fill);
  assign votes0   = fill - votes1;
  assign pred_c   = (votes1 > votes0) ? 1'b1 : (votes0 > votes1) ? 1'b0 : best_label;

  // the one comparator, its operands picked by the current step
  assign lt = (cmp_a < cmp_b);

  always_comb begin
    state_next = state;
    cmp_a      = d_r;
    cmp_b      = best_dist;
    unique case (state)
      N_IDLE: begin
        if (cmd.ins && full) begin
          state_next = (NEIGHBOURS > 1) ? N_FAR : N_REPL;
        end else if (cmd.vote && fill != '0) begin
          state_next = (fill == FILL_W'(1)) ? N_VOTE : N_NEAR;
        end
      end
      N_FAR: begin
        cmp_a = best_dist;
        cmp_b = nbr_dist[ptr];
        if (ptr_last) begin
          state_next = N_REPL;
        end
      end
      N_REPL: begin
        state_next = N_IDLE;
      end
      N_NEAR: begin
        cmp_a = nbr_dist[ptr];
        cmp_b = best_dist;
        if (ptr_end) begin
          state_next = N_VOTE;
        end
      end
      N_VOTE: begin
        state_next = N_IDLE;
      end
      default: begin
        state_next = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= N_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= 1'b0;
      if (state == N_IDLE && cmd.ins && !full) begin
        fill <= fill + FILL_W'(1);
      end
      if (state == N_IDLE && cmd.vote && fill == '0) begin
        res_valid <= 1'b1;
      end
      if (state == N_VOTE) begin
        res_valid <= 1'b1;
        fill      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (cmd.ins) begin
          if (!full) begin
            nbr_dist[fill_idx] <= d;
            lab[fill_idx]      <= cmd.label;
          end else begin
            d_r       <= d;
            lab_r     <= cmd.label;
            best_dist <= nbr_dist[0];
            best_idx  <= '0;
            ptr       <= NIDX_W'(1);
          end
        end
        if (cmd.vote) begin
          qcls_r     <= cmd.qcls;
          best_dist  <= nbr_dist[0];
          best_label <= lab[0];
          votes1     <= FILL_W'(lab[0]);
          ptr        <= NIDX_W'(1);
          // empty list: no decision
          pred       <= 1'b0;
          dec        <= 1'b0;
          keep       <= 1'b0;
        end
      end
      N_FAR: begin
        if (lt) begin
          best_dist <= nbr_dist[ptr];
          best_idx  <= ptr;
        end
        ptr <= ptr + NIDX_W'(1);
      end
      N_REPL: begin
        // replace the farthest only if strictly nearer
        if (lt) begin
          nbr_dist[best_idx] <= d_r;
          lab[best_idx]      <= lab_r;
        end
      end
      N_NEAR: begin
        if (lt) begin
          best_dist  <= nbr_dist[ptr];
          best_label <= lab[ptr];
        end
        votes1 <= votes1 + FILL_W'(lab[ptr]);
        ptr    <= ptr + NIDX_W'(1);
      end
      N_VOTE: begin
        pred <= pred_c;
        dec  <= 1'b1;
        keep <= (pred_c == qcls_r);
      end
      default: begin
      end
    endcase
  end

  assign stat.busy      = (state != N_IDLE);
  assign stat.res_valid = res_valid;
  assign stat.predicted = pred;
  assign stat.decided   = dec;
  assign stat.keep      = keep;

endmodule
